FILE: sv/fpsd_pkg.sv
// Shared types, constants and helper functions for the filtered proximity
// stepper drive. No dependencies; all files but the checker use it by scope.
package fpsd_pkg;

  localparam int PHASES      = 8;
  localparam int PHASE_W     = 3;
  localparam int LADDER_BASE = 20;
  localparam int LADDER_STEP = 5;
  localparam int LADDER_TOP  = 60;
  localparam int LADDER_N    = (LADDER_TOP - LADDER_BASE) / LADDER_STEP + 1;
  localparam int FRAC_BITS   = 14;

  localparam logic signed [15:0] RST_COEF_A1   = -16'sd25575;
  localparam logic signed [15:0] RST_COEF_A2   = 16'sd10508;
  localparam logic signed [15:0] RST_COEF_B0   = 16'sd329;
  localparam logic signed [15:0] RST_COEF_B1   = 16'sd658;
  localparam logic signed [15:0] RST_COEF_B2   = 16'sd329;
  localparam logic        [3:0]  RST_DIVIDER   = 4'd10;
  localparam logic signed [15:0] RST_STOP      = 16'sd65;
  localparam logic        [7:0]  RST_SLOWEST   = 8'd15;

  typedef enum logic [2:0] {
    REG_COEF_A1        = 3'd0,
    REG_COEF_A2        = 3'd1,
    REG_COEF_B0        = 3'd2,
    REG_COEF_B1        = 3'd3,
    REG_COEF_B2        = 3'd4,
    REG_SAMPLE_DIVIDER = 3'd5,
    REG_STOP_LEVEL     = 3'd6,
    REG_SLOWEST_PERIOD = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] coef_a1;
    logic signed [15:0] coef_a2;
    logic signed [15:0] coef_b0;
    logic signed [15:0] coef_b1;
    logic signed [15:0] coef_b2;
    logic        [3:0]  sample_divider;
    logic signed [15:0] stop_level;
    logic        [7:0]  slowest_period;
  } cfg_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_SUB,
    MAC_ADD
  } mac_op_t;

  typedef struct packed {
    mac_op_t            op;
    logic signed [15:0] opa;
    logic signed [15:0] opb;
    logic        [31:0] init;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_SUB1,
    S_SUB2,
    S_FRESH,
    S_ADD1,
    S_ADD2,
    S_ADD3,
    S_LEVEL,
    S_DECIDE,
    S_OUT
  } state_t;

  function automatic logic [7:0] coil_table(input logic [PHASE_W-1:0] idx);
    logic [7:0] pat;
    case (idx)
      3'd0:    pat = 8'hC3;
      3'd1:    pat = 8'h81;
      3'd2:    pat = 8'h99;
      3'd3:    pat = 8'h18;
      3'd4:    pat = 8'h3C;
      3'd5:    pat = 8'h24;
      3'd6:    pat = 8'h66;
      default: pat = 8'h42;
    endcase
    return pat;
  endfunction

  // count the speed thresholds the level lies above
  function automatic logic [3:0] ladder_count(input logic signed [15:0] lvl);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < LADDER_N; i++) begin
      if (lvl > $signed(16'(LADDER_BASE + LADDER_STEP * i))) n = n + 4'd1;
    end
    return n;
  endfunction

  function automatic logic signed [15:0] take_bits(input logic [31:0] sum);
    return $signed(sum[FRAC_BITS+15:FRAC_BITS]);
  endfunction

endpackage

FILE: sv/fpsd_mac.sv
// Shared multiply-accumulate unit: one registered 16x16 signed product and a
// 32-bit wrapping accumulator. Depends on fpsd_pkg.
module fpsd_mac (
  input  logic               clk,
  input  fpsd_pkg::mac_ctrl_t ctrl,
  output logic [31:0]        acc
);

  logic signed [31:0] prod;

  always_ff @(posedge clk) begin
    prod <= ctrl.opa * ctrl.opb;
    unique case (ctrl.op)
      fpsd_pkg::MAC_LOAD: acc <= ctrl.init;
      fpsd_pkg::MAC_SUB:  acc <= acc - $unsigned(prod);
      fpsd_pkg::MAC_ADD:  acc <= acc + $unsigned(prod);
      default:            acc <= acc;
    endcase
  end

endmodule

FILE: sv/fpsd_seq.sv
// Sequencer for one tick: counters, filter schedule on the shared MAC, step
// decision and the result register. Depends on fpsd_pkg and drives fpsd_mac.
module fpsd_seq (
  input  logic                clk,
  input  logic                rst,
  input  fpsd_pkg::cfg_t      cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [31:0]         m_tdata,
  output fpsd_pkg::mac_ctrl_t mac,
  input  logic [31:0]         acc
);

  fpsd_pkg::state_t state, state_next;

  logic [3:0]                   divider_count;
  logic [15:0]                  period_count;
  logic signed [15:0]           delay_one;
  logic signed [15:0]           delay_two;
  logic signed [15:0]           level;
  logic signed [15:0]           fresh;
  logic [fpsd_pkg::PHASE_W-1:0] phase_index;
  logic [7:0]                   drive_pattern;
  logic [7:0]                   sample;
  logic                         stepped;
  logic                         stopped;

  logic [3:0] div_inc;
  logic       div_match;
  logic       out_free;
  logic       stop_now;
  logic [8:0] period;
  logic       step_now;

  assign div_inc   = divider_count + 4'd1;
  assign div_match = (div_inc == cfg.sample_divider);
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == fpsd_pkg::S_IDLE);

  assign stop_now = (level > cfg.stop_level);
  assign period   = {1'b0, cfg.slowest_period} + {5'b0, fpsd_pkg::ladder_count(level)};
  assign step_now = !stop_now && ({1'b0, period_count} >= {8'b0, period});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mac.op     = fpsd_pkg::MAC_HOLD;
    mac.opa    = cfg.coef_a1;
    mac.opb    = delay_one;
    mac.init   = {10'b0, sample, 14'b0};
    unique case (state)
      fpsd_pkg::S_IDLE: begin
        if (s_tvalid) state_next = div_match ? fpsd_pkg::S_LOAD : fpsd_pkg::S_DECIDE;
      end
      fpsd_pkg::S_LOAD: begin
        mac.op     = fpsd_pkg::MAC_LOAD;
        state_next = fpsd_pkg::S_SUB1;
      end
      fpsd_pkg::S_SUB1: begin
        mac.op     = fpsd_pkg::MAC_SUB;
        mac.opa    = cfg.coef_a2;
        mac.opb    = delay_two;
        state_next = fpsd_pkg::S_SUB2;
      end
      fpsd_pkg::S_SUB2: begin
        mac.op     = fpsd_pkg::MAC_SUB;
        state_next = fpsd_pkg::S_FRESH;
      end
      fpsd_pkg::S_FRESH: begin
        // restart the sum for the feedforward half
        mac.op     = fpsd_pkg::MAC_LOAD;
        mac.init   = '0;
        mac.opa    = cfg.coef_b1;
        mac.opb    = delay_one;
        state_next = fpsd_pkg::S_ADD1;
      end
      fpsd_pkg::S_ADD1: begin
        mac.op     = fpsd_pkg::MAC_ADD;
        mac.opa    = cfg.coef_b2;
        mac.opb    = delay_two;
        state_next = fpsd_pkg::S_ADD2;
      end
      fpsd_pkg::S_ADD2: begin
        mac.op     = fpsd_pkg::MAC_ADD;
        mac.opa    = cfg.coef_b0;
        mac.opb    = fresh;
        state_next = fpsd_pkg::S_ADD3;
      end
      fpsd_pkg::S_ADD3: begin
        mac.op     = fpsd_pkg::MAC_ADD;
        state_next = fpsd_pkg::S_LEVEL;
      end
      fpsd_pkg::S_LEVEL:  state_next = fpsd_pkg::S_DECIDE;
      fpsd_pkg::S_DECIDE: state_next = fpsd_pkg::S_OUT;
      fpsd_pkg::S_OUT: begin
        if (out_free) state_next = fpsd_pkg::S_IDLE;
      end
      default: state_next = fpsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_count <= '0;
      period_count  <= '0;
      delay_one     <= '0;
      delay_two     <= '0;
      level         <= '0;
      phase_index   <= '0;
      drive_pattern <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      // drop the taken item unless a new one replaces it this cycle
      if (m_tready && !(state == fpsd_pkg::S_OUT && out_free)) m_tvalid <= 1'b0;
      case (state)
        fpsd_pkg::S_IDLE: begin
          if (s_tvalid) begin
            sample        <= s_tdata;
            divider_count <= div_match ? 4'd0 : div_inc;
            if (period_count != 16'hFFFF) period_count <= period_count + 16'd1;
          end
        end
        fpsd_pkg::S_FRESH: fresh <= fpsd_pkg::take_bits(acc);
        fpsd_pkg::S_LEVEL: begin
          level     <= fpsd_pkg::take_bits(acc);
          delay_two <= delay_one;
          delay_one <= fresh;
        end
        fpsd_pkg::S_DECIDE: begin
          stopped <= stop_now;
          stepped <= step_now;
          if (step_now) begin
            drive_pattern <= fpsd_pkg::coil_table(phase_index);
            phase_index   <= (phase_index == fpsd_pkg::PHASE_W'(fpsd_pkg::PHASES - 1))
                             ? '0 : phase_index + 1'b1;
            period_count  <= '0;
          end
        end
        fpsd_pkg::S_OUT: begin
          if (out_free) begin
            m_tdata  <= {6'b0, level, stopped, stepped, drive_pattern};
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/filtered_proximity_stepper_drive_core.sv
// Filtered proximity stepper drive, top level. A tick without a filter update
// goes from acceptance through the decide and output states; a filter tick
// first runs its five products one after another through the single shared
// multiplier. The next tick is taken only once the result has been registered.
// Synchronous active-high reset clears all filter and step state and loads
// the register defaults; no output is valid after reset.
module filtered_proximity_stepper_drive_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] sensor_sample
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] coil_pattern, [8] stepped, [9] stopped, [25:10] filtered_level
  output logic [31:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  fpsd_pkg::cfg_t      cfg;
  fpsd_pkg::mac_ctrl_t mac;
  logic [31:0]         acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_a1        <= fpsd_pkg::RST_COEF_A1;
      cfg.coef_a2        <= fpsd_pkg::RST_COEF_A2;
      cfg.coef_b0        <= fpsd_pkg::RST_COEF_B0;
      cfg.coef_b1        <= fpsd_pkg::RST_COEF_B1;
      cfg.coef_b2        <= fpsd_pkg::RST_COEF_B2;
      cfg.sample_divider <= fpsd_pkg::RST_DIVIDER;
      cfg.stop_level     <= fpsd_pkg::RST_STOP;
      cfg.slowest_period <= fpsd_pkg::RST_SLOWEST;
    end else if (cfg_valid) begin
      unique case (fpsd_pkg::cfg_reg_t'(cfg_index))
        fpsd_pkg::REG_COEF_A1:        cfg.coef_a1        <= cfg_data;
        fpsd_pkg::REG_COEF_A2:        cfg.coef_a2        <= cfg_data;
        fpsd_pkg::REG_COEF_B0:        cfg.coef_b0        <= cfg_data;
        fpsd_pkg::REG_COEF_B1:        cfg.coef_b1        <= cfg_data;
        fpsd_pkg::REG_COEF_B2:        cfg.coef_b2        <= cfg_data;
        fpsd_pkg::REG_SAMPLE_DIVIDER: cfg.sample_divider <= cfg_data[3:0];
        fpsd_pkg::REG_STOP_LEVEL:     cfg.stop_level     <= cfg_data;
        fpsd_pkg::REG_SLOWEST_PERIOD: cfg.slowest_period <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  fpsd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .mac      (mac),
    .acc      (acc)
  );

  fpsd_mac u_mac (
    .clk  (clk),
    .ctrl (mac),
    .acc  (acc)
  );

endmodule

FILE: sv/fpsd_checker.sv
// Port-level checks for the filtered proximity stepper drive, bound to the
// top level. Depends only on the top level's ports.
module fpsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // one item at a time: busy right after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous item in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_no_step_when_stopped: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[9]))
    else $error("step issued while stopped");

  a_step_pattern: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] != 8'h00)
    else $error("step issued with empty coil pattern");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind filtered_proximity_stepper_drive_core fpsd_checker u_fpsd_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);

FILE: tb/sv/tb_filtered_proximity_stepper_drive_core.sv
// Self-checking testbench for filtered_proximity_stepper_drive_core: drives
// sensor ticks and register writes, predicts every drive result in place.
// Depends on fpsd_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_filtered_proximity_stepper_drive_core;

  typedef struct packed {
    logic signed [15:0] level;
    logic               stopped;
    logic               stepped;
    logic [7:0]         coil;
  } drive_out_t;

  localparam logic [7:0] COIL_SEQ [8] = '{8'hC3, 8'h81, 8'h99, 8'h18,
                                          8'h3C, 8'h24, 8'h66, 8'h42};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  filtered_proximity_stepper_drive_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor state and register mirror
  fpsd_pkg::cfg_t     drive_cfg;
  logic [3:0]         div_cnt;
  logic [15:0]        step_timer;
  logic signed [15:0] filter_w1, filter_w2, filter_level;
  logic [2:0]         coil_phase;
  logic [7:0]         coil_now;

  logic [7:0] sample_q[$];
  drive_out_t expected_drive_q[$];
  int         error_count = 0;
  int         send_gap = 0;
  int         take_gap = 0;
  bit         send_idling = 1'b0;
  bit         take_idling = 1'b0;
  logic       tick_taken = 1'b0;
  logic       result_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_filtered_proximity_stepper_drive_core: errors");
    $finish;
  end

  function automatic fpsd_pkg::cfg_t reset_config();
    fpsd_pkg::cfg_t c;
    c.coef_a1        = fpsd_pkg::RST_COEF_A1;
    c.coef_a2        = fpsd_pkg::RST_COEF_A2;
    c.coef_b0        = fpsd_pkg::RST_COEF_B0;
    c.coef_b1        = fpsd_pkg::RST_COEF_B1;
    c.coef_b2        = fpsd_pkg::RST_COEF_B2;
    c.sample_divider = fpsd_pkg::RST_DIVIDER;
    c.stop_level     = fpsd_pkg::RST_STOP;
    c.slowest_period = fpsd_pkg::RST_SLOWEST;
    return c;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 100) $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic apply_write(input fpsd_pkg::cfg_reg_t idx, input logic [15:0] val);
    case (idx)
      fpsd_pkg::REG_COEF_A1:        drive_cfg.coef_a1 = val;
      fpsd_pkg::REG_COEF_A2:        drive_cfg.coef_a2 = val;
      fpsd_pkg::REG_COEF_B0:        drive_cfg.coef_b0 = val;
      fpsd_pkg::REG_COEF_B1:        drive_cfg.coef_b1 = val;
      fpsd_pkg::REG_COEF_B2:        drive_cfg.coef_b2 = val;
      fpsd_pkg::REG_SAMPLE_DIVIDER: drive_cfg.sample_divider = val[3:0];
      fpsd_pkg::REG_STOP_LEVEL:     drive_cfg.stop_level = val;
      fpsd_pkg::REG_SLOWEST_PERIOD: drive_cfg.slowest_period = val[7:0];
      default: ;
    endcase
  endtask

  // one timer tick: run the filter when due, then the step timer
  task automatic advance_drive(input logic [7:0] sample);
    logic [31:0]        acc;
    logic signed [15:0] fresh;
    int                 period;
    drive_out_t         o;
    div_cnt = div_cnt + 4'd1;
    if (step_timer != 16'hFFFF) step_timer = step_timer + 16'd1;
    if (div_cnt == drive_cfg.sample_divider) begin
      div_cnt = 4'd0;
      acc = {10'd0, sample, 14'd0};
      acc = acc - (int'(drive_cfg.coef_a1) * int'(filter_w1));
      acc = acc - (int'(drive_cfg.coef_a2) * int'(filter_w2));
      fresh = $signed(acc[29:14]);
      acc = (int'(drive_cfg.coef_b0) * int'(fresh))
          + (int'(drive_cfg.coef_b1) * int'(filter_w1))
          + (int'(drive_cfg.coef_b2) * int'(filter_w2));
      filter_level = $signed(acc[29:14]);
      filter_w2 = filter_w1;
      filter_w1 = fresh;
    end
    o.stepped = 1'b0;
    o.stopped = filter_level > drive_cfg.stop_level;
    if (!o.stopped) begin
      period = int'(drive_cfg.slowest_period);
      for (int th = 20; th <= 60; th += 5) begin
        if (filter_level > th) period++;
      end
      if (int'(step_timer) >= period) begin
        coil_now   = COIL_SEQ[coil_phase];
        coil_phase = (coil_phase == 3'(fpsd_pkg::PHASES - 1)) ? 3'd0 : coil_phase + 3'd1;
        step_timer = 16'd0;
        o.stepped  = 1'b1;
      end
    end
    o.coil  = coil_now;
    o.level = filter_level;
    expected_drive_q.push_back(o);
  endtask

  task automatic check_drive(input logic [31:0] data);
    drive_out_t want;
    if (expected_drive_q.size() == 0) begin
      report_error($sformatf("result %h with nothing expected", data));
      return;
    end
    want = expected_drive_q.pop_front();
    if (data[7:0] != want.coil)
      report_error($sformatf("coil_pattern %h, want %h", data[7:0], want.coil));
    if (data[8] != want.stepped)
      report_error($sformatf("stepped %b, want %b", data[8], want.stepped));
    if (data[9] != want.stopped)
      report_error($sformatf("stopped %b, want %b", data[9], want.stopped));
    if (data[25:10] != want.level)
      report_error($sformatf("filtered_level %0d, want %0d",
                             $signed(data[25:10]), want.level));
    if (data[31:26] != 6'd0)
      report_error($sformatf("pad bits %b not zero", data[31:26]));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      drive_cfg    = reset_config();
      div_cnt      = '0;
      step_timer   = '0;
      filter_w1    = '0;
      filter_w2    = '0;
      filter_level = '0;
      coil_phase   = '0;
      coil_now     = '0;
      tick_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(fpsd_pkg::cfg_reg_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) advance_drive(s_tdata);
      if (m_tvalid && m_tready) check_drive(m_tdata);
      tick_taken   <= s_tvalid && s_tready;
      result_taken <= m_tvalid && m_tready;
    end
  end

  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // sensor side: hold the item until taken, then wait out the gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || tick_taken) begin
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (sample_q.size() > 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= sample_q.pop_front();
        send_gap <= pick_gap(send_idling);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: stall for a random gap after each item
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (take_gap > 0) begin
      m_tready <= 1'b0;
      take_gap <= take_gap - 1;
    end else begin
      m_tready <= 1'b1;
      if (result_taken) take_gap <= pick_gap(take_idling);
    end
  end

  task automatic write_reg(input fpsd_pkg::cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input fpsd_pkg::cfg_t c);
    write_reg(fpsd_pkg::REG_COEF_A1, c.coef_a1);
    write_reg(fpsd_pkg::REG_COEF_A2, c.coef_a2);
    write_reg(fpsd_pkg::REG_COEF_B0, c.coef_b0);
    write_reg(fpsd_pkg::REG_COEF_B1, c.coef_b1);
    write_reg(fpsd_pkg::REG_COEF_B2, c.coef_b2);
    // upper bits are don't-care for the narrow registers
    write_reg(fpsd_pkg::REG_SAMPLE_DIVIDER, {12'($urandom), c.sample_divider});
    write_reg(fpsd_pkg::REG_STOP_LEVEL, c.stop_level);
    write_reg(fpsd_pkg::REG_SLOWEST_PERIOD, {8'($urandom), c.slowest_period});
  endtask

  // wait until every tick is taken and every result checked
  task automatic drain();
    while (sample_q.size() != 0 || s_tvalid || expected_drive_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // runs around a drifting target level, with some stray readings
  task automatic push_samples(input int n);
    int target, v;
    int run;
    while (n > 0) begin
      target = $urandom_range(0, 255);
      run = $urandom_range(4, 30);
      while (run > 0 && n > 0) begin
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 255);
        else v = target + $urandom_range(0, 16) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        sample_q.push_back(8'(v));
        run--;
        n--;
      end
    end
  endtask

  function automatic fpsd_pkg::cfg_t pick_config();
    fpsd_pkg::cfg_t c;
    int             r;
    c = reset_config();
    r = $urandom_range(0, 9);
    if (r < 6) begin
      c.coef_b0 = 16'($urandom_range(0, 1500));
      c.coef_b1 = 16'($urandom_range(0, 1500));
      c.coef_b2 = 16'($urandom_range(0, 1500));
    end else if (r < 9) begin
      c.coef_a1 = 16'($urandom);
      c.coef_a2 = 16'($urandom);
      c.coef_b0 = 16'($urandom);
      c.coef_b1 = 16'($urandom);
      c.coef_b2 = 16'($urandom);
    end else begin
      c.coef_a1 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      c.coef_a2 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      c.coef_b0 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      c.coef_b1 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      c.coef_b2 = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
    end
    c.sample_divider = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4))
                                                  : 4'($urandom_range(0, 15));
    r = $urandom_range(0, 9);
    if (r < 7)       c.stop_level = 16'(int'($urandom_range(0, 320)) - 20);
    else if (r == 7) c.stop_level = 16'h8000;
    else if (r == 8) c.stop_level = 16'h7FFF;
    else             c.stop_level = 16'($urandom);
    r = $urandom_range(0, 9);
    if (r == 0)      c.slowest_period = 8'd0;
    else if (r == 1) c.slowest_period = 8'd1;
    else if (r == 2) c.slowest_period = 8'd255;
    else             c.slowest_period = 8'($urandom_range(1, 30));
    return c;
  endfunction

  initial begin
    fpsd_pkg::cfg_t c;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register defaults, extreme readings
    send_idling = 1'b1;
    take_idling = 1'b1;
    foreach (COIL_SEQ[i]) sample_q.push_back(8'hFF);
    sample_q.push_back(8'h00);
    sample_q.push_back(8'h55);
    sample_q.push_back(8'hAA);
    sample_q.push_back(8'h01);
    drain();

    // filter every tick, no base period: steps each tick at low level
    c = reset_config();
    c.sample_divider = 4'd1;
    c.slowest_period = 8'd0;
    c.stop_level     = 16'h7FFF;
    write_all(c);
    repeat (6) sample_q.push_back(8'hFF);
    repeat (6) sample_q.push_back(8'h00);
    drain();

    // divider of zero wraps the count through all sixteen values
    write_reg(fpsd_pkg::REG_SAMPLE_DIVIDER, 16'd0);
    push_samples(20);
    drain();

    // lower the divider below a running count
    write_reg(fpsd_pkg::REG_SAMPLE_DIVIDER, 16'd15);
    push_samples(5);
    drain();
    write_reg(fpsd_pkg::REG_SAMPLE_DIVIDER, 16'd2);
    push_samples(16);
    drain();

    // hold the motor while the step timer keeps counting
    c = reset_config();
    c.coef_b0 = '0;
    c.coef_b1 = '0;
    c.coef_b2 = '0;
    c.sample_divider = 4'd15;
    c.stop_level = 16'h8000;
    write_all(c);
    send_idling = 1'b0;
    take_idling = 1'b0;
    repeat (60) sample_q.push_back(8'($urandom));
    drain();
    write_reg(fpsd_pkg::REG_STOP_LEVEL, 16'h7FFF);
    push_samples(4);
    drain();

    for (int phase_n = 0; phase_n < 7; phase_n++) begin
      write_all(pick_config());
      send_idling = ($urandom_range(0, 3) != 0);
      take_idling = ($urandom_range(0, 3) != 0);
      push_samples(90);
      // in the fourth phase, let everything settle before the rest of it
      if (phase_n == 3) drain();
      push_samples(85);
      drain();
    end

    c.coef_a1 = 16'h8000;
    c.coef_a2 = 16'h7FFF;
    c.coef_b0 = 16'h7FFF;
    c.coef_b1 = 16'h8000;
    c.coef_b2 = 16'h8000;
    c.sample_divider = 4'd1;
    c.stop_level = 16'h7FFF;
    c.slowest_period = 8'd255;
    write_all(c);
    send_idling = 1'b1;
    take_idling = 1'b1;
    push_samples(60);
    drain();

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_filtered_proximity_stepper_drive_core: clean");
    end else begin
      $display("tb_filtered_proximity_stepper_drive_core: errors");
    end
    $finish;
  end

endmodule

FILE: filtered_proximity_stepper_drive_core.f
sv/fpsd_pkg.sv
sv/fpsd_mac.sv
sv/fpsd_seq.sv
sv/filtered_proximity_stepper_drive_core.sv
sv/fpsd_checker.sv
tb/sv/tb_filtered_proximity_stepper_drive_core.sv
